// ===== src/pcl_pkg.sv =====
// Shared package for the positional circular list: sizes, operation and
// status codes, and the command/status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package pcl_pkg;

  // Number of elements the list can hold.
  localparam int CAPACITY = 64;

  // Field widths fixed by the stream format.
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Widths that follow from the capacity.
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = POS_W + 1;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_DEL_HEAD = 3'd2,
    OP_DEL_TAIL = 3'd3,
    OP_LIST     = 3'd4,
    OP_INS_AT   = 3'd5,
    OP_DEL_AT   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } st_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch the accepted item
    logic start_up;     // set up a walk toward the head (insert)
    logic start_down;   // set up a walk toward the tail (delete)
    logic start_list;   // set up a walk from the head (listing)
    logic walk_up;
    logic walk_down;
    logic walk_list;
    logic put;          // write the new value and grow the list
    logic shrink;       // shrink the list by one
    logic respond;      // load the single result of this item
    logic resp_take;    // that result carries the removed value
    st_t  resp_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  opcode;
    logic full;
    logic empty;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic up_done;
    logic fwd_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/positional_circular_list_core.sv =====
// Top level of the positional circular list: stream ports around the
// controller (pcl_ctrl) and the datapath (pcl_datapath). Uses pcl_pkg.
//
//   Channel   Direction  Carries
//   s_axis    in         tuser: opcode; tdata: value, position
//   m_axis    out        tuser: status; tdata: result_value, element_count;
//                        tlast: final result of the item
//
// One item is in work at a time; a new transfer is taken once the previous
// item has placed its last result in the output register, which need not
// have been taken yet. An insert at 0-based index k moves the elements from
// k to the tail up one place, a delete moves those behind k down one place,
// and a list reads all elements; a rejected item walks nothing. The single
// read port of the element memory sets the walk rate: one element moved or
// listed per cycle, listing only while the output is not stalled.
// Reset clears the length and all control state; element storage is not
// cleared and never needs to be. Output stalls only hold listing and the
// final result; the memory is left consistent at every step.
`default_nettype none

module positional_circular_list_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] value, [38:32] position, [39] zero
  input  logic [pcl_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  // [2:0] opcode
  input  logic [pcl_pkg::OPCODE_W-1:0]           s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [31:0] result_value, [38:32] element_count, [39] zero
  output logic [pcl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [1:0] status
  output logic [pcl_pkg::STATUS_W-1:0]           m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import pcl_pkg::*;

  dp_cmd_t                    cmd;
  dp_stat_t                   stat;
  logic signed [VALUE_W-1:0]  res_value;
  st_t                        res_status;
  logic [COUNT_W-1:0]         res_count;

  // The controller sequences each item; the handshake on the input side is
  // only open while it waits for work.
  pcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the elements in order, head at index zero, and
  // shifts them one per cycle on positional inserts and deletes.
  pcl_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_opcode   (s_axis_tuser),
    .in_value    (s_axis_tdata[VALUE_W-1:0]),
    .in_position (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_value   (res_value),
    .out_status  (res_status),
    .out_count   (res_count),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res_count, res_value});
  assign m_axis_tuser = res_status;

endmodule

`default_nettype wire

// ===== src/pcl_datapath.sv =====
// Datapath of the positional circular list: element memory, length, walk
// pointer, item latch and the result register. Uses pcl_pkg.
`default_nettype none

module pcl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  pcl_pkg::dp_cmd_t                    cmd,
  output pcl_pkg::dp_stat_t                   stat,
  input  logic [pcl_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic signed [pcl_pkg::VALUE_W-1:0]  in_value,
  input  logic [pcl_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pcl_pkg::VALUE_W-1:0]  out_value,
  output pcl_pkg::st_t                        out_status,
  output logic [pcl_pkg::COUNT_W-1:0]         out_count,
  output logic                                out_last
);
  import pcl_pkg::*;

  op_t                 opcode;
  logic [VALUE_W-1:0]  value;
  logic [POS_W-1:0]    position;

  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    ptr;
  logic [ADDR_W-1:0]   idx;

  logic [VALUE_W-1:0]  mem [CAPACITY];
  logic [VALUE_W-1:0]  rdata;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   rd_addr_next;
  logic                rd_vld;
  logic [VALUE_W-1:0]  taken;

  logic                out_free;
  logic                adv;
  logic                up_rd;
  logic                fwd_rd;
  logic                rd_issue;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic                capture;
  logic                load_out;

  // Element index the operation works on.
  always_comb begin
    unique case (opcode) inside
      OP_INS_HEAD, OP_DEL_HEAD: idx = '0;
      OP_INS_TAIL:              idx = len[ADDR_W-1:0];
      OP_DEL_TAIL:              idx = ADDR_W'(len - 1'b1);
      OP_INS_AT, OP_DEL_AT:     idx = ADDR_W'(position - 1'b1);
      default:                  idx = '0;
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign adv      = !rd_vld || out_free;

  // An insert walks from the tail down to idx; deletes and listing walk up.
  assign up_rd    = cmd.walk_up && (ptr > LEN_W'(idx));
  assign fwd_rd   = (cmd.walk_down || (cmd.walk_list && adv)) && (ptr < len);
  assign rd_issue = up_rd || fwd_rd;
  assign rd_addr_next = up_rd ? ADDR_W'(ptr - 1'b1) : ptr[ADDR_W-1:0];

  assign capture = cmd.walk_down && rd_vld && (rd_addr == idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = value;
    if (cmd.put) begin
      wr_en = 1'b1;
    end else if (cmd.walk_up && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr + 1'b1;
      wr_data = rdata;
    end else if (cmd.walk_down && rd_vld && !capture) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr - 1'b1;
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rdata <= mem[rd_addr_next];
    end
  end

  assign load_out = cmd.respond || (cmd.walk_list && rd_vld && out_free);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.put) begin
        len <= len + 1'b1;
      end else if (cmd.shrink) begin
        len <= len - 1'b1;
      end

      if (cmd.start_up) begin
        ptr <= len;
      end else if (cmd.start_down) begin
        ptr <= LEN_W'(idx);
      end else if (cmd.start_list) begin
        ptr <= '0;
      end else if (up_rd) begin
        ptr <= ptr - 1'b1;
      end else if (fwd_rd) begin
        ptr <= ptr + 1'b1;
      end

      if (cmd.start_up || cmd.start_down || cmd.start_list) begin
        rd_vld <= 1'b0;
      end else if (cmd.walk_up || cmd.walk_down || (cmd.walk_list && adv)) begin
        rd_vld <= rd_issue;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode   <= op_t'(in_opcode);
      value    <= in_value;
      position <= in_position;
    end
    if (rd_issue) begin
      rd_addr <= rd_addr_next;
    end
    if (capture) begin
      taken <= rdata;
    end
    if (load_out) begin
      out_count <= COUNT_W'(len);
      if (cmd.respond) begin
        out_value  <= cmd.resp_take ? taken : '0;
        out_status <= cmd.resp_status;
        out_last   <= 1'b1;
      end else begin
        out_value  <= rdata;
        out_status <= ST_OK;
        out_last   <= (rd_addr == ADDR_W'(len - 1'b1));
      end
    end
  end

  assign stat.opcode     = opcode;
  assign stat.full       = (len == LEN_W'(CAPACITY));
  assign stat.empty      = (len == '0);
  assign stat.ins_pos_ok = (position != '0) &&
                           (CMP_W'(position) <= CMP_W'(len) + CMP_W'(1));
  assign stat.del_pos_ok = (position != '0) && (CMP_W'(position) <= CMP_W'(len));
  assign stat.up_done    = (ptr == LEN_W'(idx)) && !rd_vld;
  assign stat.fwd_done   = (ptr == len) && !rd_vld;
  assign stat.out_free   = out_free;

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (len < LEN_W'(CAPACITY)))
    else $error("insert into a full list");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shrink |-> (len != '0))
    else $error("delete from an empty list");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (LEN_W'(rd_addr) < len))
    else $error("walk read beyond the stored elements");

  a_respond_free: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> out_free)
    else $error("result register overwritten while a result waits");

endmodule

`default_nettype wire

// ===== src/pcl_ctrl.sv =====
// Controller of the positional circular list: one-hot state machine that
// sequences decode, memory walks and the result. Uses pcl_pkg.
`default_nettype none

module pcl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcl_pkg::dp_stat_t  stat,
  output pcl_pkg::dp_cmd_t   cmd
);
  import pcl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_UP     = 7'b0000100,
    S_PUT    = 7'b0001000,
    S_DOWN   = 7'b0010000,
    S_LIST   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state, state_next;
  st_t    status, status_next;
  logic   take, take_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    take   <= take_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    status_next = status;
    take_next   = take;
    cmd         = '0;
    cmd.resp_status = status;
    cmd.resp_take   = take;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        take_next   = 1'b0;
        status_next = ST_OK;
        state_next  = S_RESP;
        unique case (stat.opcode) inside
          OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
            if (stat.full) begin
              status_next = ST_FULL;
            end else if (stat.opcode == OP_INS_AT && !stat.ins_pos_ok) begin
              status_next = ST_INVALID;
            end else begin
              cmd.start_up = 1'b1;
              state_next   = S_UP;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT: begin
            if (stat.empty) begin
              status_next = ST_EMPTY;
            end else if (stat.opcode == OP_DEL_AT && !stat.del_pos_ok) begin
              status_next = ST_INVALID;
            end else begin
              take_next      = 1'b1;
              cmd.start_down = 1'b1;
              state_next     = S_DOWN;
            end
          end
          OP_LIST: begin
            if (stat.empty) begin
              status_next = ST_EMPTY;
            end else begin
              cmd.start_list = 1'b1;
              state_next     = S_LIST;
            end
          end
          default: begin
            status_next = ST_INVALID;
          end
        endcase
      end
      S_UP: begin
        cmd.walk_up = 1'b1;
        if (stat.up_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_RESP;
      end
      S_DOWN: begin
        cmd.walk_down = 1'b1;
        if (stat.fwd_done) begin
          cmd.shrink = 1'b1;
          state_next = S_RESP;
        end
      end
      S_LIST: begin
        cmd.walk_list = 1'b1;
        if (stat.fwd_done) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
